@@ rtl/core/quoted_field_splitter_assert.svh @@
// assertion macros for the quoted field splitter checker
// no dependencies; included by files that hold concurrent assertions
`ifndef QUOTED_FIELD_SPLITTER_ASSERT_SVH
`define QUOTED_FIELD_SPLITTER_ASSERT_SVH

// assertion sampled on the rising clock edge, off while reset is held
`define QFS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion sampled on the rising clock edge, active during reset as well
`define QFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/qfs_pkg.sv @@
// shared types and constants for the quoted field splitter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package qfs_pkg;

  // configuration register indexes
  localparam logic [0:0] REG_SEPARATOR = 1'd0;
  localparam logic [0:0] REG_ESCAPE    = 1'd1;

  // configuration reset values
  localparam logic [15:0] SEP_RESET = 16'h002C;
  localparam logic [1:0]  ESC_RESET = 2'd2;

  // escape mode bits
  localparam int unsigned ESC_BIT_BSLASH = 0;
  localparam int unsigned ESC_BIT_DOUBLE = 1;

  // input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // result kinds
  localparam logic RES_CHAR = 1'b0;
  localparam logic RES_END  = 1'b1;

  // open quote codes on the final field end
  localparam logic [1:0] OQ_NONE   = 2'd0;
  localparam logic [1:0] OQ_SINGLE = 2'd1;
  localparam logic [1:0] OQ_DOUBLE = 2'd2;

  // special code units
  localparam logic [15:0] CHR_SQUOTE = 16'h0027;
  localparam logic [15:0] CHR_DQUOTE = 16'h0022;
  localparam logic [15:0] CHR_BSLASH = 16'h005C;
  localparam logic [15:0] CHR_SPACE  = 16'h0020;

  // output word layout
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic [15:0] sep;
    logic [1:0]  esc_mode;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] fchar;
    logic [1:0]  open_q;
    logic        last;
  } res_t;

endpackage

@@ rtl/core/qfs_cfg_regs.sv @@
// configuration registers of the quoted field splitter
// depends on qfs_pkg
`timescale 1ns / 1ps

module qfs_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  logic [0:0]    wr_addr_i,
  input  logic [15:0]   wr_data_i,
  output qfs_pkg::cfg_t cfg_o
);
  import qfs_pkg::*;

  logic [15:0] sep_q;
  logic [1:0]  esc_q;

  // register writes, one word per accepted write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
      esc_q <= ESC_RESET;
    end else if (wr_en_i) begin
      unique case (wr_addr_i)
        REG_SEPARATOR: sep_q <= wr_data_i;
        REG_ESCAPE:    esc_q <= wr_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.sep      = sep_q;
  assign cfg_o.esc_mode = esc_q;

endmodule

@@ rtl/core/qfs_parser.sv @@
// parse state and per-character step logic of the quoted field splitter
// depends on qfs_pkg
`timescale 1ns / 1ps

module qfs_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  qfs_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  logic          kind_i,
  input  logic [15:0]   code_unit_i,
  output logic          res_vld_o,
  output qfs_pkg::res_t res_o
);
  import qfs_pkg::*;

  typedef enum logic [2:0] {
    MODE_BEG = 3'd0,
    MODE_SEP = 3'd1,
    MODE_UNQ = 3'd2,
    MODE_Q1  = 3'd3,
    MODE_Q2  = 3'd4
  } mode_e;

  mode_e mode_q, mode_d;
  logic  cqp_q, cqp_d;
  logic  esc_q, esc_d;

  // unicode whitespace set used when the separator is a space
  function automatic logic is_white(input logic [15:0] c);
    logic w;
    w = (c >= 16'h0009 && c <= 16'h000D) || (c >= 16'h2000 && c <= 16'h200A) ||
        c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680 ||
        c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
        c == 16'h3000;
    return w;
  endfunction

  // next state and result for one item
  always_comb begin
    logic  quoted;
    logic  sep_any;
    logic  is_sep;
    logic  is_quote;
    logic  dbl;
    logic  bsl;
    mode_e m;
    mode_e own_mode;

    mode_d    = mode_q;
    cqp_d     = cqp_q;
    esc_d     = esc_q;
    res_vld_o = 1'b0;
    res_o     = '0;

    dbl      = cfg_i.esc_mode[ESC_BIT_DOUBLE];
    bsl      = cfg_i.esc_mode[ESC_BIT_BSLASH];
    m        = mode_q;
    quoted   = (mode_q == MODE_Q1) || (mode_q == MODE_Q2);
    sep_any  = (cfg_i.sep == CHR_SPACE);
    is_sep   = (code_unit_i == cfg_i.sep) || (sep_any && is_white(code_unit_i));
    is_quote = (code_unit_i == CHR_SQUOTE) || (code_unit_i == CHR_DQUOTE);
    own_mode = (code_unit_i == CHR_SQUOTE) ? MODE_Q1 : MODE_Q2;

    if (kind_i == KIND_EOL) begin
      // end of line: close the last field and return to line start
      if (cqp_q) m = MODE_UNQ;
      res_o.kind = RES_END;
      res_o.last = 1'b1;
      if (m == MODE_SEP || m == MODE_UNQ) begin
        res_vld_o = 1'b1;
      end else if (m == MODE_Q1) begin
        res_vld_o    = 1'b1;
        res_o.open_q = OQ_SINGLE;
      end else if (m == MODE_Q2) begin
        res_vld_o    = 1'b1;
        res_o.open_q = OQ_DOUBLE;
      end
      mode_d = MODE_BEG;
      cqp_d  = 1'b0;
      esc_d  = 1'b0;
    end else if (esc_q) begin
      // escaped character is taken literally
      esc_d       = 1'b0;
      if (!quoted) mode_d = MODE_UNQ;
      res_vld_o   = 1'b1;
      res_o.kind  = RES_CHAR;
      res_o.fchar = code_unit_i;
    end else if (cqp_q && ((m == MODE_Q1 && code_unit_i == CHR_SQUOTE) ||
                           (m == MODE_Q2 && code_unit_i == CHR_DQUOTE))) begin
      // doubled quote stands for one quote
      cqp_d       = 1'b0;
      res_vld_o   = 1'b1;
      res_o.kind  = RES_CHAR;
      res_o.fchar = code_unit_i;
    end else begin
      // a pending quote that is not doubled closed the field
      if (cqp_q) begin
        cqp_d  = 1'b0;
        m      = MODE_UNQ;
        quoted = 1'b0;
        mode_d = MODE_UNQ;
      end
      res_o.fchar = code_unit_i;
      if (is_quote) begin
        if (m == own_mode) begin
          if (dbl) cqp_d = 1'b1;
          else mode_d = MODE_UNQ;
        end else if (m == MODE_UNQ || quoted) begin
          res_vld_o = 1'b1;
        end else begin
          mode_d = own_mode;
        end
      end else if (is_sep) begin
        if (quoted) begin
          res_vld_o = 1'b1;
        end else if (m == MODE_SEP) begin
          // runs of whitespace collapse into one field end
          if (!sep_any) begin
            res_vld_o   = 1'b1;
            res_o.kind  = RES_END;
            res_o.fchar = '0;
          end
        end else begin
          mode_d      = MODE_SEP;
          res_vld_o   = 1'b1;
          res_o.kind  = RES_END;
          res_o.fchar = '0;
        end
      end else if (code_unit_i == CHR_BSLASH && bsl) begin
        esc_d = 1'b1;
      end else begin
        if (!quoted) mode_d = MODE_UNQ;
        res_vld_o = 1'b1;
      end
      if (!res_vld_o) res_o.fchar = '0;
    end
  end

  // parse state, advanced once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BEG;
      cqp_q  <= 1'b0;
      esc_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      cqp_q  <= cqp_d;
      esc_q  <= esc_d;
    end
  end

endmodule

@@ rtl/core/quoted_field_splitter.sv @@
// Quoted field splitter: takes one 16-bit code unit or end-of-line mark per word and
// gives at most one result word, a field character or a field end. Each word passes an
// input register and then, through the parse logic, the result register; the sustained
// rate is one word per clock while the result stream is not stalled. The parse step
// waits while a result word is stalled, so a stalled output lets one more input word
// into the input register and then holds the input as well. Words that yield no result
// (an opening or closing quote, an escape backslash, an empty line) leave no output word.
// Configuration writes are always accepted and must only occur while the block is idle.
// depends on qfs_pkg, qfs_cfg_regs, qfs_parser
`timescale 1ns / 1ps

module quoted_field_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tuser_i,   // [0] kind
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [qfs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o, // [15:0] field_char,
                                                         // [17:16] open_quote, rest zero
  output logic        m_axis_tuser_o,   // [0] result_kind
  output logic        m_axis_tlast_o,   // line_done
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);
  import qfs_pkg::*;

  cfg_t        cfg;
  logic        in_vld_q;
  logic        in_kind_q;
  logic [15:0] in_cu_q;
  logic        out_vld_q;
  res_t        out_res_q;
  logic        out_free;
  logic        step;
  logic        res_vld;
  res_t        res;

  assign cfg_ready_o = 1'b1;

  qfs_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_addr_i (cfg_addr_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // pipeline flow control
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_kind_q <= s_axis_tuser_i;
      in_cu_q   <= s_axis_tdata_i;
    end
  end

  qfs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .kind_i      (in_kind_q),
    .code_unit_i (in_cu_q),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= res_vld;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_vld) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - 18){1'b0}}, out_res_q.open_q, out_res_q.fchar};
  assign m_axis_tuser_o  = out_res_q.kind;
  assign m_axis_tlast_o  = out_res_q.last;

endmodule

@@ rtl/core/qfs_checker.sv @@
// port-level checks for the quoted field splitter, bound to the top level
// depends on qfs_pkg and quoted_field_splitter_assert.svh
`timescale 1ns / 1ps
`include "quoted_field_splitter_assert.svh"

module qfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [qfs_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import qfs_pkg::*;

  // a stalled result word holds
  `QFS_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o),
    "result word changed while stalled")
  // character words carry no quote flag and no line end
  `QFS_ASSERT(a_char_clean, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o == RES_CHAR |->
      m_axis_tdata_o[17:16] == OQ_NONE && !m_axis_tlast_o,
    "character word with field end flags")
  // open quote only on the final field end, and the field end carries no character
  `QFS_ASSERT(a_end_clean, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o == RES_END |->
      m_axis_tdata_o[15:0] == '0 && (m_axis_tlast_o || m_axis_tdata_o[17:16] == OQ_NONE),
    "malformed field end word")
  // open quote code and padding stay in range
  `QFS_ASSERT(a_pad_zero, clk_i, rst_ni,
    m_axis_tvalid_o |->
      m_axis_tdata_o[OUT_DATA_W-1:18] == '0 && m_axis_tdata_o[17:16] != 2'd3,
    "bad open quote code or padding")

endmodule

bind quoted_field_splitter qfs_checker u_qfs_checker (.*);
